>>> hw/rtl/tgfb_pkg.sv
// ---------------------------------------------------------------------------
// tgfb_pkg: shared constants and types for the triangle fragment blender
// Register indexes, default coordinate width and channel layout.
// ---------------------------------------------------------------------------
`default_nettype none

package tgfb_pkg;

	localparam int COORD_BITS_DEF = 13;
	localparam int VTX_REG_W      = 26;
	localparam int COLOR_W        = 32;
	localparam int CHAN_N         = 4;
	localparam int CFG_IDX_W      = 3;
	localparam int PIX_W          = 12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VERTEX_A = 3'd0,
		REG_VERTEX_B = 3'd1,
		REG_VERTEX_C = 3'd2,
		REG_COLOR_A  = 3'd3,
		REG_COLOR_B  = 3'd4,
		REG_COLOR_C  = 3'd5
	} cfg_reg_t;

endpackage

`default_nettype wire

>>> hw/rtl/triangle_gouraud_fragment_blend_top.sv
// Throughput: one item per cycle while the output is not stalled; set by the
// 16-stage pipeline, whose eight division stages resolve one quotient bit each.
// A stalled output holding a valid item holds every stage; the input stalls only then.
// Reset clears all valid bits and the six registers to zero.
// ---------------------------------------------------------------------------
// triangle_gouraud_fragment_blend_top: barycentric fragment shade and blend
// Coverage test, per-channel color interpolation and alpha blend over the
// framebuffer word, fully pipelined.
// ---------------------------------------------------------------------------
`default_nettype none

module triangle_gouraud_fragment_blend_top
	import tgfb_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COLOR_W-1:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [PIX_W-1:0]     pixel_x,
	input  wire logic [PIX_W-1:0]     pixel_y,
	input  wire logic [COLOR_W-1:0]   dest_pixel,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      covered,
	output logic [COLOR_W-1:0]        pixel_out
);

	localparam int CB   = COORD_BITS;
	localparam int DW   = ((CB > PIX_W) ? CB : PIX_W) + 2;
	localparam int WW   = 2 * DW + 3;
	localparam int SW   = WW + 10;
	localparam int XW   = (2 * CB > VTX_REG_W) ? 2 * CB : VTX_REG_W;
	localparam int NST  = 16;

	logic [VTX_REG_W-1:0] vtx_a_q, vtx_b_q, vtx_c_q;
	logic [COLOR_W-1:0]   col_a_q, col_b_q, col_c_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_a_q <= '0;
			vtx_b_q <= '0;
			vtx_c_q <= '0;
			col_a_q <= '0;
			col_b_q <= '0;
			col_c_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VERTEX_A: vtx_a_q <= cfg_data[VTX_REG_W-1:0];
				REG_VERTEX_B: vtx_b_q <= cfg_data[VTX_REG_W-1:0];
				REG_VERTEX_C: vtx_c_q <= cfg_data[VTX_REG_W-1:0];
				REG_COLOR_A:  col_a_q <= cfg_data;
				REG_COLOR_B:  col_b_q <= cfg_data;
				REG_COLOR_C:  col_c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control: every stage moves unless the output is held
	logic           adv;
	logic [NST:1]   v_q;

	assign adv       = !(v_q[NST] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = v_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[NST-1:1], in_valid};
		end
	end

	// vertex coordinates
	logic [XW-1:0]        va_ext, vb_ext, vc_ext;
	logic signed [CB-1:0] xa, ya, xb, yb, xc, yc;

	assign va_ext = XW'(vtx_a_q);
	assign vb_ext = XW'(vtx_b_q);
	assign vc_ext = XW'(vtx_c_q);
	assign xa = va_ext[CB-1:0];
	assign ya = va_ext[2*CB-1:CB];
	assign xb = vb_ext[CB-1:0];
	assign yb = vb_ext[2*CB-1:CB];
	assign xc = vc_ext[CB-1:0];
	assign yc = vc_ext[2*CB-1:CB];

	// stage 1: differences
	logic signed [DW-1:0] dx_s1, dy_s1, e1_s1, e2_s1, e3_s1, e4_s1;
	logic [COLOR_W-1:0]   dst_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1  <= $signed({{(DW-PIX_W){1'b0}}, pixel_x}) - DW'(xc);
			dy_s1  <= $signed({{(DW-PIX_W){1'b0}}, pixel_y}) - DW'(yc);
			e1_s1  <= DW'(yb) - DW'(yc);
			e2_s1  <= DW'(xc) - DW'(xb);
			e3_s1  <= DW'(yc) - DW'(ya);
			e4_s1  <= DW'(xa) - DW'(xc);
			dst_s1 <= dest_pixel;
		end
	end

	// stage 2: products
	logic signed [2*DW-1:0] p1a_s2, p1b_s2, p2a_s2, p2b_s2, pda_s2, pdb_s2;
	logic [COLOR_W-1:0]     dst_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			p1a_s2 <= e1_s1 * dx_s1;
			p1b_s2 <= e2_s1 * dy_s1;
			p2a_s2 <= e3_s1 * dx_s1;
			p2b_s2 <= e4_s1 * dy_s1;
			pda_s2 <= e4_s1 * e1_s1;
			pdb_s2 <= e2_s1 * e3_s1;
			dst_s2 <= dst_s1;
		end
	end

	// stage 3: weights u1, u2 and det
	logic signed [WW-1:0] u1_s3, u2_s3, det_s3;
	logic [COLOR_W-1:0]   dst_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			u1_s3  <= WW'(p1a_s2) + WW'(p1b_s2);
			u2_s3  <= WW'(p2a_s2) + WW'(p2b_s2);
			det_s3 <= WW'(pda_s2) - WW'(pdb_s2);
			dst_s3 <= dst_s2;
		end
	end

	// stage 4: third weight, coverage, magnitudes
	logic signed [WW-1:0] u3_c;
	logic                 cov_c;
	logic [WW-1:0]        m1_s4, m2_s4, m3_s4, md_s4;
	logic                 cov_s4;
	logic [COLOR_W-1:0]   dst_s4;

	function automatic logic agrees(input logic signed [WW-1:0] u,
		input logic signed [WW-1:0] d);
		return (u == '0) || (u[WW-1] && d[WW-1]) ||
			(!u[WW-1] && !d[WW-1] && d != '0);
	endfunction

	function automatic logic [WW-1:0] mag(input logic signed [WW-1:0] u);
		return u[WW-1] ? WW'(-u) : WW'(u);
	endfunction

	assign u3_c  = det_s3 - u1_s3 - u2_s3;
	assign cov_c = agrees(u1_s3, det_s3) && agrees(u2_s3, det_s3) &&
		agrees(u3_c, det_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s4  <= mag(u1_s3);
			m2_s4  <= mag(u2_s3);
			m3_s4  <= mag(u3_c);
			md_s4  <= mag(det_s3);
			cov_s4 <= cov_c;
			dst_s4 <= dst_s3;
		end
	end

	// stage 5: color times weight per channel
	logic [WW+7:0]      ta_s5 [CHAN_N];
	logic [WW+7:0]      tb_s5 [CHAN_N];
	logic [WW+7:0]      tc_s5 [CHAN_N];
	logic [WW-1:0]      md_s5;
	logic               cov_s5;
	logic [COLOR_W-1:0] dst_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < CHAN_N; k++) begin
				ta_s5[k] <= (WW+8)'(col_a_q[8*k +: 8]) * (WW+8)'(m1_s4);
				tb_s5[k] <= (WW+8)'(col_b_q[8*k +: 8]) * (WW+8)'(m2_s4);
				tc_s5[k] <= (WW+8)'(col_c_q[8*k +: 8]) * (WW+8)'(m3_s4);
			end
			md_s5  <= md_s4;
			cov_s5 <= cov_s4;
			dst_s5 <= dst_s4;
		end
	end

	// stage 6 feeds the divider: remainder, quotient and side data per step
	logic [SW-1:0]      rem_d [0:8][CHAN_N];
	logic [7:0]         quo_d [0:8][CHAN_N];
	logic [WW-1:0]      md_d  [0:8];
	logic               cov_d [0:8];
	logic [COLOR_W-1:0] dst_d [0:8];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < CHAN_N; k++) begin
				rem_d[0][k] <= SW'(ta_s5[k]) + SW'(tb_s5[k]) + SW'(tc_s5[k]);
				quo_d[0][k] <= '0;
			end
			md_d[0]  <= md_s5;
			cov_d[0] <= cov_s5;
			dst_d[0] <= dst_s5;
		end
	end

	// stages 7..14: one quotient bit each, most significant first
	for (genvar i = 0; i < 8; i++) begin : g_div
		logic [SW-1:0] dsh;
		assign dsh = SW'(md_d[i]) << (7 - i);

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int k = 0; k < CHAN_N; k++) begin
					if (rem_d[i][k] >= dsh) begin
						rem_d[i+1][k] <= rem_d[i][k] - dsh;
						quo_d[i+1][k] <= quo_d[i][k] | (8'd1 << (7 - i));
					end else begin
						rem_d[i+1][k] <= rem_d[i][k];
						quo_d[i+1][k] <= quo_d[i][k];
					end
				end
				md_d[i+1]  <= md_d[i];
				cov_d[i+1] <= cov_d[i];
				dst_d[i+1] <= dst_d[i];
			end
		end
	end

	// stage 15: blend sums; a zero det gives color 0
	logic [7:0]         src_c [CHAN_N];
	logic [16:0]        bl_s15 [3];
	logic               cov_s15;
	logic [COLOR_W-1:0] dst_s15;

	always_comb begin
		for (int k = 0; k < CHAN_N; k++) begin
			src_c[k] = (md_d[8] == '0) ? 8'd0 : quo_d[8][k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				bl_s15[k] <= 17'(dst_d[8][8*k +: 8]) * 17'(8'd255 - src_c[3]) +
					17'(src_c[k]) * 17'(src_c[3]);
			end
			cov_s15 <= cov_d[8];
			dst_s15 <= dst_d[8];
		end
	end

	// stage 16: divide by 255 via reciprocal form, pick pass-through
	logic [COLOR_W-1:0] blend_c;

	always_comb begin
		logic [16:0] t;
		blend_c = {dst_s15[31:24], 24'd0};
		for (int k = 0; k < 3; k++) begin
			t = bl_s15[k] + 17'd1 + (bl_s15[k] >> 8);
			blend_c[8*k +: 8] = t[15:8];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			covered   <= cov_s15;
			pixel_out <= cov_s15 ? blend_c : dst_s15;
		end
	end

`ifndef SYNTH
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !v_q[NST-1]) |=> !out_valid)
		else $error("output item repeated");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[1] && in_stall) |=> v_q[1])
		else $error("stage one item lost during stall");
`endif

endmodule

`default_nettype wire
